>>> rtl/lts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the lexical token scanner.
// No dependencies.
package lts_pkg;

	localparam int LEXLENGTH = 32;
	localparam int CNT_W = $clog2(LEXLENGTH + 1);
	localparam int IDX_W = $clog2(LEXLENGTH);
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int MEM_AW = QPTR_W + IDX_W;
	localparam int NKW = 19;
	localparam int KW_BASE = 23;
	localparam int KW_MAXLEN = 9;
	localparam logic [30:0] LIMIT_RESET = 31'd32767;

	typedef enum logic [5:0] {
		K_IDENT = 6'd0, K_NUMBER = 6'd1, K_STRING = 6'd2, K_EOF = 6'd3,
		K_UNKNOWN = 6'd4, K_PLUS = 6'd5, K_MINUS = 6'd6, K_STAR = 6'd7,
		K_SLASH = 6'd8, K_LPAREN = 6'd9, K_RPAREN = 6'd10, K_LBRACK = 6'd11,
		K_RBRACK = 6'd12, K_EQ = 6'd13, K_SEMI = 6'd14, K_COMMA = 6'd15,
		K_PERIOD = 6'd16, K_LT = 6'd17, K_GT = 6'd18, K_BECOMES = 6'd19,
		K_LE = 6'd20, K_NE = 6'd21, K_GE = 6'd22
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE = 2'd0, E_OVERFLOW = 2'd1, E_UNTERM = 2'd2
	} err_t;

	localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [NKW] = '{
		"BEGIN", "COBEGIN", "COEND", "CONST", "DO", "END", "FUNCTION", "IF",
		"PROCEDURE", "PROGRAM", "READ", "RETURN", "SIGNAL", "STACKDUMP", "THEN",
		"VAR", "WAIT", "WHILE", "WRITE"
	};

	typedef struct packed {
		logic [7:0] source_char;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [30:0] number_value;
		logic [7:0]  text_char;
		logic [4:0]  text_index;
		logic [5:0]  text_length;
		logic        last_of_token;
		logic [1:0]  error_code;
	} out_item_t;

	// one finished token waiting for serialization
	typedef struct packed {
		logic [5:0]       kind;
		logic [30:0]      num;
		logic [CNT_W-1:0] len;
		logic [1:0]       err;
	} desc_t;

	typedef struct packed {
		logic [1:0]        n;
		desc_t             d0;
		desc_t             d1;
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [7:0]        wdata;
	} push_t;

	typedef struct packed {
		logic [QPTR_W-1:0] wr_ptr;
		logic              space;
	} qstat_t;

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			"=": k = K_EQ;
			";": k = K_SEMI;
			",": k = K_COMMA;
			".": k = K_PERIOD;
			"<": k = K_LT;
			">": k = K_GT;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	// text is right-justified, zero padded; chars of an identifier are never zero
	function automatic logic [5:0] ident_kind(input logic [8*KW_MAXLEN-1:0] text,
		input logic [CNT_W-1:0] cnt);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = 0; i < NKW; i++) begin
			if (cnt <= CNT_W'(KW_MAXLEN) && text == KW_TEXT[i])
				k = 6'(KW_BASE + i);
		end
		return k;
	endfunction

endpackage

>>> rtl/lts_front.sv
`timescale 1ns / 1ps
// Scanner front end: takes one character per transaction, tracks the token in
// progress and commits finished tokens and text to lts_queue. Uses lts_pkg.
module lts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lts_pkg::in_item_t   in_data,
	input  logic [30:0]         limit,
	input  lts_pkg::qstat_t     qstat,
	output lts_pkg::push_t      push
);

	typedef enum logic [5:0] {
		M_IDLE  = 6'b000001,
		M_IDENT = 6'b000010,
		M_NUM   = 6'b000100,
		M_STR   = 6'b001000,
		M_STRQ  = 6'b010000,
		M_OP    = 6'b100000
	} mode_t;

	mode_t                            mode_q, n_mode;
	logic [lts_pkg::CNT_W-1:0]        count_q, n_count;
	logic [30:0]                      acc_q, n_acc;
	logic                             ovf_q, n_ovf;
	logic [7:0]                       op_first_q, n_op_first;
	logic [8*lts_pkg::KW_MAXLEN-1:0]  kw_q, n_kw;

	logic       acc_en;
	logic [7:0] c, upc;
	logic       eol, is_alpha, is_digit, rescan, c1, c2;
	logic [3:0] dig;
	logic [34:0] prod;
	logic        dig_ok;
	logic        put, put_room, swr;
	logic [7:0]  swr_char;
	logic [lts_pkg::QPTR_W-1:0] sslot;
	lts_pkg::desc_t d1, d2;
	logic [5:0]  cmp_kind;

	assign acc_en = in_valid && in_ready;
	assign in_ready = qstat.space;
	assign c = in_data.source_char;
	assign eol = in_data.line_end;
	assign is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	assign is_digit = c >= "0" && c <= "9";
	assign upc = (c >= "a") ? c - 8'd32 : c;
	assign dig = c[3:0];
	assign put_room = count_q < lts_pkg::CNT_W'(lts_pkg::LEXLENGTH);

	// acc <= (limit - d) / 10, truncated toward zero
	assign prod = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, dig};
	assign dig_ok = ({27'd0, dig} <= limit) ? (prod <= {4'd0, limit}) : (acc_q == 31'd0);

	always_comb begin
		n_mode = mode_q;
		n_count = count_q;
		n_acc = acc_q;
		n_ovf = ovf_q;
		n_op_first = op_first_q;
		n_kw = kw_q;
		rescan = 1'b0;
		c1 = 1'b0;
		c2 = 1'b0;
		put = 1'b0;
		swr = 1'b0;
		swr_char = c;
		d1 = '0;
		d2 = '0;
		d1.len = count_q;
		cmp_kind = 6'd0;
		case (mode_q)
			M_IDENT: begin
				if (is_alpha || is_digit) begin
					put = 1'b1;
					if (count_q < lts_pkg::CNT_W'(lts_pkg::KW_MAXLEN))
						n_kw = {kw_q[8*lts_pkg::KW_MAXLEN-9:0], is_alpha ? upc : c};
				end else begin
					c1 = 1'b1;
					d1.kind = lts_pkg::ident_kind(kw_q, count_q);
					rescan = 1'b1;
				end
			end
			M_NUM: begin
				if (is_digit) begin
					put = 1'b1;
					if (dig_ok) n_acc = prod[30:0];
					else n_ovf = 1'b1;
				end else begin
					c1 = 1'b1;
					d1.kind = lts_pkg::K_NUMBER;
					d1.num = acc_q;
					d1.err = ovf_q ? lts_pkg::E_OVERFLOW : lts_pkg::E_NONE;
					rescan = 1'b1;
				end
			end
			M_STR: begin
				if (count_q != '0 && eol) begin
					c1 = 1'b1;
					d1.kind = lts_pkg::K_STRING;
					d1.err = lts_pkg::E_UNTERM;
					rescan = 1'b1;
				end else if (c == "'") begin
					n_mode = M_STRQ;
				end else begin
					put = 1'b1;
				end
			end
			M_STRQ: begin
				if (c == "'") begin
					put = 1'b1;
					n_mode = M_STR;
				end else begin
					c1 = 1'b1;
					d1.kind = lts_pkg::K_STRING;
					rescan = 1'b1;
				end
			end
			M_OP: begin
				if (op_first_q == ":" && c == "=") cmp_kind = lts_pkg::K_BECOMES;
				else if (op_first_q == "<" && c == "=") cmp_kind = lts_pkg::K_LE;
				else if (op_first_q == "<" && c == ">") cmp_kind = lts_pkg::K_NE;
				else if (op_first_q == ">" && c == "=") cmp_kind = lts_pkg::K_GE;
				c1 = 1'b1;
				if (cmp_kind != 6'd0) begin
					put = 1'b1;
					d1.kind = cmp_kind;
					d1.len = count_q + 1'b1;
					n_mode = M_IDLE;
				end else begin
					d1.kind = lts_pkg::single_kind(op_first_q);
					rescan = 1'b1;
				end
			end
			default: rescan = 1'b1;
		endcase
		if (put && put_room) n_count = count_q + 1'b1;
		if (rescan) begin
			n_mode = M_IDLE;
			n_count = '0;
			if (c == " ") begin
				n_mode = M_IDLE;
			end else if (is_alpha) begin
				swr = 1'b1;
				swr_char = upc;
				n_count = lts_pkg::CNT_W'(1);
				n_kw = {{(8*lts_pkg::KW_MAXLEN-8){1'b0}}, upc};
				n_mode = M_IDENT;
			end else if (is_digit) begin
				swr = 1'b1;
				n_count = lts_pkg::CNT_W'(1);
				n_acc = {27'd0, dig};
				n_ovf = 1'b0;
				n_mode = M_NUM;
			end else if (c == ":" || c == "<" || c == ">") begin
				swr = 1'b1;
				n_count = lts_pkg::CNT_W'(1);
				n_op_first = c;
				n_mode = M_OP;
			end else if (c == "'") begin
				n_mode = M_STR;
			end else if (c == 8'd0) begin
				c2 = 1'b1;
				d2.kind = lts_pkg::K_EOF;
			end else begin
				swr = 1'b1;
				c2 = 1'b1;
				d2.kind = lts_pkg::single_kind(c);
				d2.len = lts_pkg::CNT_W'(1);
			end
		end
	end

	assign sslot = qstat.wr_ptr + lts_pkg::QPTR_W'(c1);

	always_comb begin
		push = '0;
		if (acc_en) begin
			push.n = {1'b0, c1} + {1'b0, c2};
			push.d0 = c1 ? d1 : d2;
			push.d1 = d2;
			push.we = swr || (put && put_room);
		end
		push.waddr = swr ? {sslot, lts_pkg::IDX_W'(0)}
		                 : {qstat.wr_ptr, count_q[lts_pkg::IDX_W-1:0]};
		push.wdata = swr ? swr_char : (mode_q == M_IDENT ? upc : c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			count_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			op_first_q <= '0;
			kw_q <= '0;
		end else if (acc_en) begin
			mode_q <= n_mode;
			count_q <= n_count;
			acc_q <= n_acc;
			ovf_q <= n_ovf;
			op_first_q <= n_op_first;
			kw_q <= n_kw;
		end
	end

endmodule

>>> rtl/lts_queue.sv
`timescale 1ns / 1ps
// Token queue between scanner and serializer: descriptor ring plus token text
// memory, one text slot per descriptor. Uses lts_pkg.
module lts_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lts_pkg::push_t                   push,
	output lts_pkg::qstat_t                  qstat,
	output logic                             head_valid,
	output lts_pkg::desc_t                   head,
	output logic [lts_pkg::QPTR_W-1:0]       head_ptr,
	input  logic                             pop,
	input  logic                             rd_en,
	input  logic [lts_pkg::MEM_AW-1:0]       rd_addr,
	output logic [7:0]                       rd_data
);

	lts_pkg::desc_t desc_q [lts_pkg::QDEPTH];
	logic [7:0] mem [2**lts_pkg::MEM_AW];
	logic [lts_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [lts_pkg::QCNT_W-1:0] cnt_q;
	logic [lts_pkg::QPTR_W-1:0] wr_p1;

	assign wr_p1 = wr_q + 1'b1;
	assign head_valid = cnt_q != '0;
	assign head = desc_q[rd_q];
	assign head_ptr = rd_q;
	assign qstat.wr_ptr = wr_q;
	// room for two commits plus the slot being built
	assign qstat.space = cnt_q <= lts_pkg::QCNT_W'(lts_pkg::QDEPTH - 3);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) desc_q[wr_q] <= push.d0;
		if (push.n == 2'd2) desc_q[wr_p1] <= push.d1;
		if (push.we) mem[push.waddr] <= push.wdata;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + lts_pkg::QPTR_W'(push.n);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + lts_pkg::QCNT_W'(push.n) - lts_pkg::QCNT_W'(pop);
		end
	end

endmodule

>>> rtl/lts_back.sv
`timescale 1ns / 1ps
// Serializer: walks the head token one text character per cycle into the
// output register while not stalled. Uses lts_pkg; text memory read port lives in lts_queue.
module lts_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  lts_pkg::desc_t              head,
	input  logic [lts_pkg::QPTR_W-1:0]  head_ptr,
	output logic                        pop,
	output logic                        rd_en,
	output logic [lts_pkg::MEM_AW-1:0]  rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lts_pkg::out_item_t          out_data
);

	logic [lts_pkg::IDX_W-1:0] idx_q;
	logic [lts_pkg::CNT_W-1:0] runs_m1;
	logic                      last, load;

	lts_pkg::desc_t            desc_s1;
	logic [lts_pkg::IDX_W-1:0] idx_s1;
	logic                      last_s1;
	logic                      valid_s1;

	assign runs_m1 = (head.len == '0) ? '0 : head.len - 1'b1;
	assign last = {1'b0, idx_q} == runs_m1;
	assign load = head_valid && (!valid_s1 || out_ready);
	assign pop = load && last;
	assign rd_en = load;
	assign rd_addr = {head_ptr, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (load) idx_q <= last ? '0 : idx_q + 1'b1;
			if (load) valid_s1 <= 1'b1;
			else if (out_ready) valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_s1 <= head;
			idx_s1 <= idx_q;
			last_s1 <= last;
		end
	end

	assign out_valid = valid_s1;
	assign out_data.token_kind = desc_s1.kind;
	assign out_data.number_value = desc_s1.num;
	assign out_data.text_char = (desc_s1.len == '0) ? 8'd0 : rd_data;
	assign out_data.text_index = 5'(idx_s1);
	assign out_data.text_length = 6'(desc_s1.len);
	assign out_data.last_of_token = last_s1;
	assign out_data.error_code = desc_s1.err;

endmodule

>>> rtl/lexical_token_scanner_unit.sv
`timescale 1ns / 1ps
// Lexical token scanner, top level.
// Channels: in (source_char, line_end), out (one token text character per
// transaction), cfg (number_limit write data). All are valid/ready.
// The scanner front end takes one character per cycle whenever the token
// queue has at least three free entries; it commits finished tokens into an
// 8-entry descriptor queue with a 32-character text slot each.
// The serializer emits one result per cycle while the receiver accepts: a token
// of n text characters leaves as max(n,1) results, the last marked last_of_token.
// A token's first result appears once its descriptor has been written into
// the queue and its first text character has been read from the text memory
// into the output register.
// One character in per cycle while in_ready is high; one result out per cycle
// while the receiver accepts. Sustained input rate is set by output bandwidth
// when tokens are long, since every stored character costs one output result.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready drops once six tokens are waiting.
// Reset empties the queue, clears the scanner to between-tokens and loads
// number_limit with 32767. cfg writes are always accepted.
module lexical_token_scanner_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lts_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lts_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data
);

	logic [30:0] limit_q;
	lts_pkg::qstat_t qstat;
	lts_pkg::push_t  push;
	logic head_valid, pop, rd_en;
	lts_pkg::desc_t head;
	logic [lts_pkg::QPTR_W-1:0] head_ptr;
	logic [lts_pkg::MEM_AW-1:0] rd_addr;
	logic [7:0] rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= lts_pkg::LIMIT_RESET;
		else if (cfg_valid && cfg_ready) limit_q <= cfg_data;
	end

	lts_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .limit(limit_q), .qstat(qstat), .push(push)
	);

	lts_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .qstat(qstat),
		.head_valid(head_valid), .head(head), .head_ptr(head_ptr), .pop(pop),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	lts_back u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head),
		.head_ptr(head_ptr), .pop(pop), .rd_en(rd_en), .rd_addr(rd_addr),
		.rd_data(rd_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

>>> rtl/lts_checker.sv
`timescale 1ns / 1ps
// Port-level checks for lexical_token_scanner_unit, attached by bind.
// Uses lts_pkg for the payload types.
module lts_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               out_valid,
	input  logic               out_ready,
	input  lts_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// text of one token streams without gaps
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_token |=>
		out_valid && out_data.text_index == $past(out_data.text_index) + 5'd1)
		else $error("token run broken");

	a_num_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind != lts_pkg::K_NUMBER |->
		out_data.number_value == 31'd0)
		else $error("number_value on non-number token");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.text_length == 6'd0 |->
		out_data.last_of_token && out_data.text_char == 8'd0 &&
		out_data.text_index == 5'd0)
		else $error("empty token malformed");

endmodule

bind lexical_token_scanner_unit lts_checker u_lts_checker (.*);
